// ===== hdl/itcf_pkg.sv =====
`timescale 1ns / 1ps
// itcf_pkg: shared types, constants and the check byte function for the
// inverter torque command frame builder; no dependencies
package itcf_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_GO1,
		S_DIV1,
		S_TAPER,
		S_MUL2,
		S_GO2,
		S_DIV2,
		S_OFFSET,
		S_OUT
	} state_t;

	// configuration register indexes
	localparam logic [1:0] REG_TORQUE_MAX  = 2'd0;
	localparam logic [1:0] REG_TAPER_UPPER = 2'd1;
	localparam logic [1:0] REG_TAPER_LOWER = 2'd2;
	localparam logic [1:0] REG_SPEED_MAX   = 2'd3;

	// register reset values
	localparam logic [12:0] TORQUE_MAX_RST  = 13'd3000;
	localparam logic [14:0] TAPER_UPPER_RST = 15'd500;
	localparam logic [14:0] TAPER_LOWER_RST = 15'd75;
	localparam logic [14:0] SPEED_MAX_RST   = 15'd6000;

	localparam logic [14:0] PCT_DIVISOR   = 15'd100;
	localparam logic [18:0] TORQUE_OFFSET = 19'd32128;
	localparam logic [15:0] CMD_MAX       = 16'hFFFF;

	// control byte codes
	localparam logic [1:0] CTRL_ENABLED  = 2'b10;
	localparam logic [1:0] CTRL_DISABLED = 2'b01;
	localparam logic [1:0] CTRL_FORWARD  = 2'b10;
	localparam logic [1:0] CTRL_REVERSE  = 2'b01;

	localparam logic [7:0] CRC_SEED  = 8'h7F;
	localparam logic [7:0] CTRL_ENFW = 8'hA0;
	localparam logic [7:0] CTRL_DSFW = 8'h60;

	typedef logic [7:0] crc_tbl_t [16];
	localparam crc_tbl_t CRC_TABLE = '{
		8'hAA, 8'h7F, 8'hFE, 8'h29, 8'h52, 8'hA4, 8'h9D, 8'hEF,
		8'h0B, 8'h16, 8'h2C, 8'h58, 8'hB0, 8'h60, 8'hC0, 8'h01
	};

	// request to the shared divider
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [14:0] divisor;
	} div_req_t;

	// check byte over control byte and torque command
	function automatic logic [7:0] check_byte(input logic [7:0] ctrl, input logic [15:0] tq);
		logic [15:0] t;
		logic [7:0]  crc;
		t = tq;
		if (((ctrl & CTRL_ENFW) == CTRL_ENFW) || ((ctrl & CTRL_DSFW) == CTRL_DSFW)) begin
			t = t + 16'd1;
		end
		if (t[1:0] == 2'b11) begin
			t = t + 16'd4;
		end
		crc = CRC_SEED;
		for (int i = 0; i < 16; i++) begin
			if (t[i]) begin
				crc = crc ^ CRC_TABLE[i];
			end
		end
		return crc;
	endfunction

endpackage

// ===== hdl/inverter_torque_command_frame_top.sv =====
`timescale 1ns / 1ps
// inverter_torque_command_frame_top: builds one torque command frame per
// input beat; depends on itcf_pkg and itcf_div
//
// channel | dir | handshake           | payload
// --------+-----+---------------------+------------------------------------------
// s_      | in  | s_tvalid/s_tready   | enable, forward, throttle, motor_speed
// m_      | out | m_tvalid/m_tready   | control_byte, torque_command, security_byte
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// divider: the throttle scaling and, when the regeneration taper applies, the
//   taper both go through the shared 32-step serial divider
// reset: arst_n clears the sequencer, sequence count, output valid and loads
//   the register defaults
// stalls: a finished frame waits in the output register; the next input beat
//   is taken meanwhile, and the sequencer holds before its final write only
//   while that register is still full and m_tready is low
module inverter_torque_command_frame_top
	import itcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [0] enable, [1] forward, [12:2] throttle, [27:13] motor_speed
	// output beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] control_byte, [23:8] torque_command, [31:24] security_byte
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	// configuration registers
	logic [12:0] torque_max_q;
	logic [14:0] taper_upper_q;
	logic [14:0] taper_lower_q;
	logic [14:0] speed_max_q;

	// sequencer
	state_t state_q, state_d;
	logic [2:0] seq_q;

	// captured item
	logic        en_q;
	logic        fwd_q;
	logic        neg_q;        // throttle sign
	logic [10:0] thr_mag_q;    // throttle magnitude
	logic [14:0] speed_q;

	// working values
	logic [16:0] mag_q;        // request magnitude
	logic [14:0] pos_q;        // speed above lower taper
	logic [14:0] span_q;       // taper span
	logic [31:0] prod_q;
	logic [15:0] cmd_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic        in_acc;
	logic        out_load;
	div_req_t    div_req;
	logic        div_done;
	logic [31:0] div_quot;

	// shared multiplier operands
	logic [16:0] mul_a;
	logic [14:0] mul_b;

	// final offset stage
	logic signed [17:0] req_s;
	logic signed [17:0] req_adj;
	logic signed [18:0] cmd_sum;
	logic [15:0]        cmd_sat;
	logic [7:0]         ctrl_byte;
	logic [10:0]        thr_in;
	logic               taper_on;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign thr_in    = s_tdata[12:2];

	// regeneration with speed under the upper taper point
	assign taper_on = neg_q && (mag_q != '0) && (speed_q < taper_upper_q);

	itcf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_max_q  <= TORQUE_MAX_RST;
			taper_upper_q <= TAPER_UPPER_RST;
			taper_lower_q <= TAPER_LOWER_RST;
			speed_max_q   <= SPEED_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TORQUE_MAX:  torque_max_q  <= cfg_data[12:0];
				REG_TAPER_UPPER: taper_upper_q <= cfg_data;
				REG_TAPER_LOWER: taper_lower_q <= cfg_data;
				REG_SPEED_MAX:   speed_max_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// state register, sequence count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				seq_q <= seq_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and unit control
	always_comb begin
		state_d          = state_q;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = PCT_DIVISOR;
		mul_a            = {6'd0, thr_mag_q};
		mul_b            = {2'd0, torque_max_q};
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: state_d = S_GO1;
			S_GO1: begin
				div_req.start = 1'b1;
				state_d       = S_DIV1;
			end
			S_DIV1: begin
				if (div_done) begin
					state_d = S_TAPER;
				end
			end
			S_TAPER: begin
				if (taper_on && (speed_q >= taper_lower_q)) begin
					state_d = S_MUL2;
				end else begin
					state_d = S_OFFSET;
				end
			end
			S_MUL2: begin
				mul_a   = mag_q;
				mul_b   = pos_q;
				state_d = S_GO2;
			end
			S_GO2: begin
				div_req.start   = 1'b1;
				div_req.divisor = span_q;
				state_d         = S_DIV2;
			end
			S_DIV2: begin
				if (div_done) begin
					state_d = S_OFFSET;
				end
			end
			S_OFFSET: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// signed request, overspeed halving (floor), offset and saturation
	always_comb begin
		req_s   = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		req_adj = (speed_q > speed_max_q) ? (req_s >>> 1) : req_s;
		cmd_sum = $signed(TORQUE_OFFSET) + $signed({req_adj[17], req_adj});
		if (cmd_sum < 0) begin
			cmd_sat = '0;
		end else if (cmd_sum > $signed({3'd0, CMD_MAX})) begin
			cmd_sat = CMD_MAX;
		end else begin
			cmd_sat = cmd_sum[15:0];
		end
	end

	assign ctrl_byte = {en_q ? CTRL_ENABLED : CTRL_DISABLED,
		fwd_q ? CTRL_FORWARD : CTRL_REVERSE, 1'b0, seq_q};

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			en_q      <= s_tdata[0];
			fwd_q     <= s_tdata[1];
			neg_q     <= thr_in[10];
			thr_mag_q <= thr_in[10] ? (11'd0 - thr_in) : thr_in;
			speed_q   <= s_tdata[27:13];
		end
		if (state_q == S_MUL1 || state_q == S_MUL2) begin
			prod_q <= 32'(mul_a) * 32'(mul_b);
		end
		if ((state_q == S_DIV1 || state_q == S_DIV2) && div_done) begin
			mag_q <= div_quot[16:0];
		end
		if (state_q == S_TAPER) begin
			pos_q  <= speed_q - taper_lower_q;
			span_q <= taper_upper_q - taper_lower_q;
			// regen below the lower taper point gives no torque
			if (taper_on && (speed_q < taper_lower_q)) begin
				mag_q <= '0;
			end
		end
		if (state_q == S_OFFSET) begin
			cmd_q <= cmd_sat;
		end
		if (out_load) begin
			out_data_q <= {check_byte(ctrl_byte, cmd_q), cmd_q, ctrl_byte};
		end
	end

endmodule

// ===== hdl/itcf_div.sv =====
`timescale 1ns / 1ps
// itcf_div: restoring divider, one quotient bit per cycle, 32-bit dividend
// over a 15-bit divisor; depends on itcf_pkg
module itcf_div
	import itcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] acc_q;
	logic [14:0] rem_q;
	logic [14:0] dvs_q;
	logic [15:0] trial;
	logic [15:0] diff;
	logic        ge;

	assign trial = {rem_q, acc_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[14:0] : trial[14:0];
			acc_q <= {acc_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule
